[sv/brf_pkg.sv]
// Shared types and constants for the byte ring FIFO.
// Used by the front end, back end, top level and checker; no dependencies.
package brf_pkg;

    localparam int CNT_W        = 11;   // width of counts reported on results
    localparam int ADDR_W       = 16;   // widest ring address carried in a command
    localparam int BURST_W      = 7;    // holds a get count up to 64
    localparam int CQ_DEPTH     = 4;    // front-to-back command queue
    localparam int OQ_DEPTH     = 4;    // result queue
    localparam int OQ_CW        = 3;    // result queue occupancy width
    localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;

    typedef enum logic [1:0] {
        MODE_PUT     = 2'd0,
        MODE_GET     = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_RESET   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        KIND_GET_DATA   = 3'd0,
        KIND_GET_NONE   = 3'd1,
        KIND_PUT_COUNT  = 3'd2,
        KIND_REL_COUNT  = 3'd3,
        KIND_RESET_DONE = 3'd4
    } t_kind;

    typedef struct packed {
        t_mode              mode;
        logic [7:0]         data_byte;
        logic               last_of_put;
        logic [CNT_W-1:0]   request_count;
    } t_in;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         out_byte;
        logic [CNT_W-1:0]   moved_count;
        logic               last_result;
        logic [CNT_W-1:0]   free_space;
        logic [CNT_W-1:0]   fill_level;
    } t_out;

    // One unit of work for the back end, in program order.
    typedef struct packed {
        logic               do_write;
        logic               do_read;
        logic               do_result;
        t_kind              kind;
        logic [7:0]         data;
        logic [ADDR_W-1:0]  addr;
        logic [BURST_W-1:0] count;
        logic [CNT_W-1:0]   moved;
        logic [CNT_W-1:0]   free;
        logic [CNT_W-1:0]   fill;
    } t_cmd;

endpackage

[sv/brf_queue.sv]
// Small register FIFO carrying any packed type.
// Standalone; no package dependencies.
module brf_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  T                           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic                       o_empty,
    output T                           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH+1);

    T                r_slot [DEPTH];
    logic [IW-1:0]   r_wr;
    logic [IW-1:0]   r_rd;
    logic [NW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_slot[r_rd];
    assign o_count = r_cnt;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == IW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == IW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + NW'(do_push) - NW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

[sv/brf_front.sv]
// Front end: size register, ring counters, put tally; turns each word into a command.
// Depends on brf_pkg.
module brf_front #(
    parameter int MAX_DEPTH     = 1024,
    parameter int MAX_GET_BURST = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  brf_pkg::t_in                    i_item,
    input  logic                            i_cfg_we,
    input  logic [3:0]                      i_cfg_data,
    output logic                            o_cmd_push,
    output brf_pkg::t_cmd                   o_cmd,
    output logic [$clog2(MAX_DEPTH+1)-2:0]  o_mask
);
    import brf_pkg::*;

    localparam int CW     = $clog2(MAX_DEPTH+1);
    localparam int MAX_LG = CW - 1;
    localparam int AW     = MAX_LG;
    localparam int XW     = (CW > CNT_W) ? CW : CNT_W;

    logic [3:0]        r_size_log2;
    logic [CW-1:0]     r_wr, n_wr;
    logic [CW-1:0]     r_rd, n_rd;
    logic [CNT_W-1:0]  r_tally, n_tally;

    logic [4:0]        lg;
    logic [CW-1:0]     sz;
    logic [AW-1:0]     mask;
    logic [CW-1:0]     fill;
    logic [CW-1:0]     fill_new;
    logic              space;
    logic [XW-1:0]     req_x, fill_x, get_n, rel_n;

    // Size in use: zero reads as one, beyond the built depth is cut down.
    always_comb begin
        if (r_size_log2 == 4'd0) begin
            lg = 5'd1;
        end else if (5'(r_size_log2) > 5'(MAX_LG)) begin
            lg = 5'(MAX_LG);
        end else begin
            lg = 5'(r_size_log2);
        end
    end

    assign sz     = CW'(1) << lg;
    assign mask   = AW'(sz - CW'(1));
    assign o_mask = mask;
    assign fill   = r_wr - r_rd;
    assign space  = (fill < sz);
    assign req_x  = XW'(i_item.request_count);
    assign fill_x = XW'(fill);

    always_comb begin
        get_n = req_x;
        if (get_n > XW'(MAX_GET_BURST)) begin
            get_n = XW'(MAX_GET_BURST);
        end
        if (get_n > fill_x) begin
            get_n = fill_x;
        end
        rel_n = (req_x > fill_x) ? fill_x : req_x;
    end

    always_comb begin
        n_wr       = r_wr;
        n_rd       = r_rd;
        n_tally    = r_tally;
        o_cmd      = '0;
        o_cmd.kind = KIND_GET_NONE;
        o_cmd_push = 1'b0;
        if (i_accept) begin
            unique case (i_item.mode)
                MODE_PUT: begin
                    o_cmd.do_write = space;
                    o_cmd.addr     = ADDR_W'(r_wr[AW-1:0] & mask);
                    o_cmd.data     = i_item.data_byte;
                    if (space) begin
                        n_wr = r_wr + CW'(1);
                        if (r_tally != '1) begin
                            n_tally = r_tally + CNT_W'(1);
                        end
                    end
                    if (i_item.last_of_put) begin
                        o_cmd.do_result = 1'b1;
                        o_cmd.kind      = KIND_PUT_COUNT;
                        o_cmd.moved     = n_tally;
                        n_tally         = '0;
                    end
                    o_cmd_push = space || i_item.last_of_put;
                end
                MODE_GET: begin
                    n_rd        = r_rd + CW'(get_n);
                    o_cmd.addr  = ADDR_W'(r_rd[AW-1:0] & mask);
                    o_cmd.count = BURST_W'(get_n);
                    o_cmd.moved = CNT_W'(get_n);
                    if (get_n == '0) begin
                        o_cmd.do_result = 1'b1;
                        o_cmd.kind      = KIND_GET_NONE;
                    end else begin
                        o_cmd.do_read = 1'b1;
                        o_cmd.kind    = KIND_GET_DATA;
                    end
                    o_cmd_push = 1'b1;
                end
                MODE_RELEASE: begin
                    n_rd            = r_rd + CW'(rel_n);
                    o_cmd.do_result = 1'b1;
                    o_cmd.kind      = KIND_REL_COUNT;
                    o_cmd.moved     = CNT_W'(rel_n);
                    o_cmd_push      = 1'b1;
                end
                MODE_RESET: begin
                    n_wr            = '0;
                    n_rd            = '0;
                    n_tally         = '0;
                    o_cmd.do_result = 1'b1;
                    o_cmd.kind      = KIND_RESET_DONE;
                    o_cmd_push      = 1'b1;
                end
            endcase
        end
        // status after the whole operation
        fill_new   = n_wr - n_rd;
        o_cmd.fill = CNT_W'(fill_new);
        o_cmd.free = CNT_W'(sz - fill_new);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= SIZE_LOG2_RESET;
            r_wr        <= '0;
            r_rd        <= '0;
            r_tally     <= '0;
        end else if (i_cfg_we) begin
            r_size_log2 <= i_cfg_data;
            r_wr        <= '0;
            r_rd        <= '0;
            r_tally     <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_tally <= n_tally;
        end
    end

endmodule

[sv/brf_back.sv]
// Back end: ring memory, in-order writes and get bursts, result staging.
// Depends on brf_pkg.
module brf_back #(
    parameter int MAX_DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  brf_pkg::t_cmd                   i_cmd,
    input  logic                            i_cmd_empty,
    output logic                            o_cmd_pop,
    input  logic [$clog2(MAX_DEPTH+1)-2:0]  i_mask,
    input  logic [brf_pkg::OQ_CW-1:0]       i_out_count,
    output logic                            o_push,
    output brf_pkg::t_out                   o_res
);
    import brf_pkg::*;

    localparam int AW = $clog2(MAX_DEPTH+1) - 1;

    logic [7:0]          r_ring [1 << AW];
    logic [7:0]          r_rd_data;

    logic                r_busy, n_busy;
    logic [AW-1:0]       r_addr, n_addr;
    logic [BURST_W-1:0]  r_left, n_left;
    t_cmd                r_cur, n_cur;
    logic                r_emit_v, n_emit_v;
    logic                r_emit_mem, n_emit_mem;
    t_out                r_emit, n_emit;

    logic                go;
    logic                we, re;
    logic [AW-1:0]       wa, ra;
    t_cmd                src;

    // leave a slot for the word already staged
    assign go  = (i_out_count + OQ_CW'(r_emit_v)) < OQ_CW'(OQ_DEPTH);
    assign src = r_busy ? r_cur : i_cmd;

    always_comb begin
        n_busy      = r_busy;
        n_addr      = r_addr;
        n_left      = r_left;
        n_cur       = r_cur;
        n_emit_v    = 1'b0;
        n_emit_mem  = 1'b0;
        n_emit      = '0;
        n_emit.kind        = src.kind;
        n_emit.moved_count = src.moved;
        n_emit.free_space  = src.free;
        n_emit.fill_level  = src.fill;
        o_cmd_pop   = 1'b0;
        we          = 1'b0;
        re          = 1'b0;
        wa          = i_cmd.addr[AW-1:0];
        ra          = r_addr;
        if (r_busy) begin
            if (go) begin
                re                 = 1'b1;
                n_emit_v           = 1'b1;
                n_emit_mem         = 1'b1;
                n_emit.last_result = (r_left == BURST_W'(1));
                n_addr             = (r_addr + AW'(1)) & i_mask;
                n_left             = r_left - BURST_W'(1);
                if (r_left == BURST_W'(1)) begin
                    n_busy = 1'b0;
                end
            end
        end else if (!i_cmd_empty && go) begin
            o_cmd_pop = 1'b1;
            we        = i_cmd.do_write;
            if (i_cmd.do_read) begin
                re                 = 1'b1;
                ra                 = i_cmd.addr[AW-1:0];
                n_emit_v           = 1'b1;
                n_emit_mem         = 1'b1;
                n_emit.last_result = (i_cmd.count == BURST_W'(1));
                n_cur              = i_cmd;
                n_addr             = (i_cmd.addr[AW-1:0] + AW'(1)) & i_mask;
                n_left             = i_cmd.count - BURST_W'(1);
                n_busy             = (i_cmd.count != BURST_W'(1));
            end else if (i_cmd.do_result) begin
                n_emit_v           = 1'b1;
                n_emit.last_result = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_ring[wa] <= i_cmd.data;
        end
        if (re) begin
            r_rd_data <= r_ring[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_emit_v <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_emit_v <= n_emit_v;
        end
        r_addr     <= n_addr;
        r_left     <= n_left;
        r_cur      <= n_cur;
        r_emit     <= n_emit;
        r_emit_mem <= n_emit_mem;
    end

    always_comb begin
        o_res          = r_emit;
        o_res.out_byte = r_emit_mem ? r_rd_data : 8'd0;
    end
    assign o_push = r_emit_v;

endmodule

[sv/byte_ring_fifo_top.sv]
// Top level of the byte ring FIFO: front end, command queue, back end, result queue.
// Depends on brf_pkg, brf_queue, brf_front and brf_back.
//
// Usage
//   Input words go in on i_item with i_push; a word is taken on an edge where
//   i_push is high and o_full is low. Results come out on o_result while
//   o_empty is low and leave on an edge where i_pop is high.
//   The size register is written through i_cfg_valid / i_cfg_data; o_cfg_ready
//   is always high. A write also clears both counters and the put tally, and
//   must only be made while the block is idle.
// Timing
//   One input word per cycle is taken while the command queue has room.
//   A result passes through the command queue, the back end and the result queue.
//   A get of more than one byte keeps the back end busy, one byte per cycle while
//   the result queue has room, since the ring has a single read port; other commands do not.
//   When the back end is busy, the four-entry command queue absorbs input
//   words until it fills and o_full rises.
// Stalls and reset
//   If the receiver stops popping, the four-entry result queue fills, the back
//   end holds, then the command queue fills and o_full goes high. Nothing is
//   lost. Reset empties both queues and clears the counters, the put tally
//   and sets size_log2 to 10; ring contents are not cleared (no clearing pass).
module byte_ring_fifo_top #(
    parameter int MAX_DEPTH     = 1024,
    parameter int MAX_GET_BURST = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  brf_pkg::t_in   i_item,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output brf_pkg::t_out  o_result,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [3:0]     i_cfg_data
);
    import brf_pkg::*;

    localparam int AW = $clog2(MAX_DEPTH+1) - 1;

    logic               in_accept;
    logic               cmd_push;
    t_cmd               cmd_in;
    t_cmd               cmd_head;
    logic               cmd_empty;
    logic               cmd_pop;
    logic [AW-1:0]      ring_mask;
    logic               out_push;
    t_out               out_word;
    logic               out_full;
    logic [OQ_CW-1:0]   out_count;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_push && !o_full;

    brf_front #(
        .MAX_DEPTH     (MAX_DEPTH),
        .MAX_GET_BURST (MAX_GET_BURST)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .o_mask     (ring_mask)
    );

    // decouples word intake from burst playback
    brf_queue #(
        .T     (t_cmd),
        .DEPTH (CQ_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (o_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_head),
        .o_count ()
    );

    brf_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_mask      (ring_mask),
        .i_out_count (out_count),
        .o_push      (out_push),
        .o_res       (out_word)
    );

    brf_queue #(
        .T     (t_out),
        .DEPTH (OQ_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_word),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_result),
        .o_count (out_count)
    );

    // back end credit check must never overrun the result queue
    a_no_out_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("result queue pushed while full");

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("back end popped an empty command queue");

    a_byte_only_on_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_result.kind == KIND_GET_DATA || o_result.out_byte == 8'd0))
        else $error("non-data result carries a byte");

    a_fill_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> (cmd_in.do_write || cmd_in.do_read || cmd_in.do_result))
        else $error("empty command queued");

endmodule

[dv/brf_checker.sv]
`timescale 1ns / 100ps
// Result checker for the byte ring FIFO: watches the input, result and size-write channels.
// Keeps its own model of the ring and counters; depends on brf_pkg.
module brf_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic           i_full,
    input  brf_pkg::t_in   i_item,
    input  logic           i_empty,
    input  logic           i_pop,
    input  brf_pkg::t_out  i_result,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  logic [3:0]     i_cfg_data,
    output int             o_fail_count,
    output int             o_pending
);
    import brf_pkg::*;

    localparam int RING_MAX  = 1024;
    localparam int BURST_MAX = 64;
    localparam int TALLY_MAX = 2047;

    logic [7:0]  ring_mem [RING_MAX];
    int unsigned wr_cnt;
    int unsigned rd_cnt;
    int unsigned run_tally;
    logic [3:0]  size_sel;
    t_out        result_q [$];
    int          errors = 0;

    // size 0 counts as 1; anything past the built depth folds back to it
    function automatic int unsigned ring_len(logic [3:0] lg);
        int unsigned s;
        s = (lg == 4'd0) ? 2 : (1 << lg);
        while (s > RING_MAX) s = s >> 1;
        return s;
    endfunction

    // occupancy is taken after the whole operation has updated the counters
    task automatic queue_result(t_kind k, logic [7:0] b, int unsigned moved, logic fin);
        t_out        r;
        int unsigned s;
        int unsigned h;
        s = ring_len(size_sel);
        h = wr_cnt - rd_cnt;
        r.kind        = k;
        r.out_byte    = b;
        r.moved_count = CNT_W'(moved);
        r.last_result = fin;
        r.free_space  = CNT_W'((h <= s) ? (s - h) : 0);
        r.fill_level  = CNT_W'(h);
        result_q.push_back(r);
    endtask

    task automatic apply_word(t_in w);
        int unsigned s;
        int unsigned h;
        int unsigned n;
        logic [7:0]  taken [BURST_MAX];
        s = ring_len(size_sel);
        h = wr_cnt - rd_cnt;
        case (w.mode)
            MODE_PUT: begin
                if (h < s) begin
                    ring_mem[wr_cnt & (s - 1)] = w.data_byte;
                    wr_cnt++;
                    if (run_tally < TALLY_MAX) run_tally++;
                end
                if (w.last_of_put) begin
                    n = run_tally;
                    run_tally = 0;
                    queue_result(KIND_PUT_COUNT, 8'd0, n, 1'b1);
                end
            end
            MODE_GET: begin
                n = w.request_count;
                if (n > BURST_MAX) n = BURST_MAX;
                if (n > h) n = h;
                if (n == 0) begin
                    queue_result(KIND_GET_NONE, 8'd0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) taken[i] = ring_mem[(rd_cnt + i) & (s - 1)];
                    rd_cnt += n;
                    for (int i = 0; i < n; i++)
                        queue_result(KIND_GET_DATA, taken[i], n, i == n - 1);
                end
            end
            MODE_RELEASE: begin
                n = w.request_count;
                if (n > h) n = h;
                rd_cnt += n;
                queue_result(KIND_REL_COUNT, 8'd0, n, 1'b1);
            end
            default: begin
                wr_cnt    = 0;
                rd_cnt    = 0;
                run_tally = 0;
                queue_result(KIND_RESET_DONE, 8'd0, 0, 1'b1);
            end
        endcase
    endtask

    task automatic check_result(t_out got);
        t_out want;
        if (result_q.size() == 0) begin
            $error("unexpected result word: kind %0d fill_level %0d", got.kind, got.fill_level);
            errors++;
        end else begin
            want = result_q.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0d, actual %0d", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.moved_count !== want.moved_count) begin
                $error("moved_count: expected %0d, actual %0d", want.moved_count,
                       got.moved_count);
                errors++;
            end
            if (got.last_result !== want.last_result) begin
                $error("last_result: expected %0d, actual %0d", want.last_result,
                       got.last_result);
                errors++;
            end
            if (got.free_space !== want.free_space) begin
                $error("free_space: expected %0d, actual %0d", want.free_space, got.free_space);
                errors++;
            end
            if (got.fill_level !== want.fill_level) begin
                $error("fill_level: expected %0d, actual %0d", want.fill_level, got.fill_level);
                errors++;
            end
        end
    endtask

    // results leave before new words are modeled, so a word pushed on the
    // same edge never stands in for the one being popped
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_q.delete();
            wr_cnt    = 0;
            rd_cnt    = 0;
            run_tally = 0;
            size_sel  = SIZE_LOG2_RESET;
        end else begin
            if (i_pop && !i_empty) check_result(i_result);
            if (i_cfg_valid && i_cfg_ready) begin
                size_sel  = i_cfg_data;
                wr_cnt    = 0;
                rd_cnt    = 0;
                run_tally = 0;
            end
            if (i_push && !i_full) apply_word(i_item);
        end
        o_pending    <= result_q.size();
        o_fail_count <= errors;
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Testbench top for byte_ring_fifo_top: clock, reset, stimulus and the verdict.
// Depends on brf_pkg, the block and brf_checker, which does all prediction.
module tb;
    import brf_pkg::*;

    // generous: well above the length of the slowest legal run
    localparam int LIMIT = 2_000_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    t_in         item      = '0;
    logic        full;
    logic        empty;
    logic        pop       = 1'b0;
    t_out        result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data  = 4'd0;
    int          fail_cnt;
    int          pending;

    int          cycle_cnt = 0;
    int          ring_now  = 1024;  // ring size in use, only to shape random runs
    bit          fast_send = 1'b0;  // stretches of back-to-back input words
    bit          fast_recv = 1'b0;  // stretches of popping every cycle

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    byte_ring_fifo_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .i_item      (item),
        .o_full      (full),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    brf_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (result),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_cnt),
        .o_pending    (pending)
    );

    // Push one input word. The gap comes first, so when it is zero push
    // simply stays high and the next word follows on the very next edge.
    // Signals are read right after the edge, i.e. as the block saw them.
    task automatic send_word(t_in w);
        int gap;
        if ($urandom_range(0, 29) == 0) fast_send = !fast_send;
        gap = fast_send ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= w;
        do @(posedge clk); while (full);
    endtask

    // Stop sending and wait until every predicted result word has been popped.
    // The pending count is registered, so always advance before looking.
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Size writes only while idle: after the last result, non-closing puts may
    // still sit in the command queue, so give the pipeline time to empty.
    task automatic write_size(logic [3:0] v);
        drain_results();
        repeat (16) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ring_now = (v == 4'd0) ? 2 : (v > 4'd10) ? 1024 : (1 << v);
    endtask

    task automatic send_put(logic [7:0] b, logic fin);
        t_in w;
        w = '0;
        w.mode        = MODE_PUT;
        w.data_byte   = b;
        w.last_of_put = fin;
        send_word(w);
    endtask

    task automatic send_cmd(t_mode m, int cnt);
        t_in w;
        w = '0;
        w.mode          = m;
        w.request_count = CNT_W'(cnt);
        send_word(w);
    endtask

    // Mostly well-formed traffic: put runs closed by a last byte, gets and
    // releases sized around the ring, a few counter resets. The rest is
    // unclosed runs and fully random words.
    task automatic random_items(int n);
        int   sent;
        int   r;
        int   len;
        int   top_len;
        logic close;
        t_in  w;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            w.mode          = MODE_PUT;
            w.data_byte     = 8'($urandom);
            w.last_of_put   = 1'($urandom);
            w.request_count = CNT_W'($urandom);
            if (r < 45) begin
                top_len = (ring_now + 4 > 80) ? 80 : ring_now + 4;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, top_len)
                    : $urandom_range(1, (ring_now < 16) ? ring_now + 2 : 16);
                close = ($urandom_range(0, 7) != 0);
                for (int k = 0; k < len; k++) begin
                    w.data_byte   = 8'($urandom);
                    w.last_of_put = close && (k == len - 1);
                    send_word(w);
                end
                sent += len;
            end else begin
                if (r < 70) begin
                    w.mode = MODE_GET;
                    case ($urandom_range(0, 9))
                        0:       w.request_count = CNT_W'($urandom);
                        1, 2:    w.request_count = CNT_W'($urandom_range(17, 80));
                        default: w.request_count = CNT_W'($urandom_range(0, 16));
                    endcase
                end else if (r < 85) begin
                    w.mode = MODE_RELEASE;
                    if ($urandom_range(0, 4) != 0)
                        w.request_count = CNT_W'($urandom_range(0, ring_now));
                end else if (r < 88) begin
                    w.mode = MODE_RESET;
                end else begin
                    w.mode = t_mode'($urandom_range(0, 3));
                end
                send_word(w);
                sent++;
            end
            // occasionally hold off until the block has said everything
            if ($urandom_range(0, 49) == 0) drain_results();
        end
    endtask

    // Receiver: random stall before each word, with stretches of no stalls.
    initial begin
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) fast_recv = !fast_recv;
            stall = fast_recv ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    // Watchdog on a cycle count.
    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [3:0] sizes [8];
        sizes = '{4'd1, 4'd10, 4'd0, 4'd2, 4'd15, 4'd5, 4'd3, 4'd7};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, default size of 1024 after reset ---
        send_put(8'h00, 1'b0);
        send_put(8'hFF, 1'b1);              // run of two
        send_cmd(MODE_GET, 0);              // zero count finds nothing
        send_cmd(MODE_GET, 1);
        send_cmd(MODE_GET, 2047);           // capped, then clamped to one byte
        send_cmd(MODE_GET, 5);              // nothing held
        send_cmd(MODE_RELEASE, 1024);       // release on an empty ring
        send_put(8'hA5, 1'b0);
        send_put(8'h5A, 1'b0);
        send_cmd(MODE_RESET, 0);            // also clears the open run tally
        send_put(8'h3C, 1'b1);
        send_cmd(MODE_RELEASE, 1024);       // more than held

        // two-entry ring: bytes that find it full are dropped
        write_size(4'd1);
        send_put(8'h11, 1'b0);
        send_put(8'h22, 1'b0);
        send_put(8'h33, 1'b1);
        send_put(8'h44, 1'b1);              // lone byte into a full ring
        send_cmd(MODE_GET, 2047);
        send_cmd(MODE_GET, 64);

        // size zero behaves as size one
        write_size(4'd0);
        send_put(8'h81, 1'b0);
        send_put(8'h7E, 1'b1);
        send_cmd(MODE_GET, 1);
        send_cmd(MODE_GET, 1);

        // oversized setting folds back to the full 1024 ring
        write_size(4'd15);
        for (int k = 0; k < 6; k++) send_put(8'($urandom), 1'b0);
        send_put(8'hC3, 1'b1);
        send_cmd(MODE_GET, 64);             // clamped to the bytes held
        send_cmd(MODE_RELEASE, 2047);

        // --- random phases over several sizes ---
        foreach (sizes[p]) begin
            write_size(sizes[p]);
            random_items(26);
            drain_results();                // sender holds until all results are in
            random_items(26);
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[byte_ring_fifo_top.f]
sv/brf_pkg.sv
sv/brf_queue.sv
sv/brf_front.sv
sv/brf_back.sv
sv/byte_ring_fifo_top.sv
dv/brf_checker.sv
dv/tb.sv
